### sv/rac_pkg.sv
// Shared constants, types and helpers for the restricted-alphabet radix converter.
// No dependencies; rac_ctrl, rac_dp and the top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rac_pkg;

	// Sizing of the converter
	localparam int MAX_SYMBOLS = 36;
	localparam int VALUE_BITS  = 63;
	localparam int DIGIT_DEPTH = 64;

	// Fixed field widths
	localparam int SYM_COUNT_W = 6;
	localparam int MASK_W      = 36;
	localparam int DV_W        = 6;
	localparam int ASCII_W     = 7;
	localparam int CFG_IDX_W   = 2;

	// Derived widths
	localparam int SYM_IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int BASE_W    = $clog2(MAX_SYMBOLS + 1);
	localparam int DIG_AW    = $clog2(DIGIT_DEPTH);
	localparam int CNT_W     = $clog2(DIGIT_DEPTH + 1);
	localparam int BIT_CNT_W = $clog2(VALUE_BITS);

	// Character codes
	localparam logic [ASCII_W-1:0] CHAR_ZERO      = 7'h30;
	localparam logic [ASCII_W-1:0] CHAR_A         = 7'h41;
	localparam logic [ASCII_W-1:0] DECIMAL_DIGITS = 7'd10;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BANNED_MASK  = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_CHECK,
		ST_DIV,
		ST_NEXT,
		ST_RD,
		ST_MAP,
		ST_EMIT,
		ST_EMPTY,
		ST_ERR
	} state_t;

	typedef struct packed {
		logic load;
		logic sweep;
		logic div_start;
		logic div_step;
		logic out_init;
		logic rd_digit;
		logic rd_map;
		logic emit_digit;
		logic emit_empty;
		logic emit_err;
		logic ptr_dec;
	} cmd_t;

	typedef struct packed {
		logic in_zero;
		logic sweep_last;
		logic base_lt2;
		logic div_last;
		logic quot_zero;
		logic count_full;
		logic ptr_zero;
	} status_t;

	// ASCII code of alphabet position idx: 0-9 then A-Z
	function automatic logic [ASCII_W-1:0] to_ascii(input logic [SYM_IDX_W-1:0] idx);
		logic [ASCII_W-1:0] wide;
		wide = ASCII_W'(idx);
		if (wide < DECIMAL_DIGITS) begin
			to_ascii = CHAR_ZERO + wide;
		end else begin
			to_ascii = CHAR_A + (wide - DECIMAL_DIGITS);
		end
	endfunction

endpackage

`default_nettype wire

### sv/rac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/rac_ctrl.sv
// Sequencing state machine of the radix converter.
// Depends on rac_pkg for state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module rac_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire rac_pkg::status_t sts,
	output logic                  busy,
	output rac_pkg::cmd_t         cmd
);

	rac_pkg::state_t state_q;
	rac_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rac_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rac_pkg::ST_IDLE: begin
				if (start) begin
					state_d = sts.in_zero ? rac_pkg::ST_EMPTY : rac_pkg::ST_SWEEP;
				end
			end
			rac_pkg::ST_SWEEP: begin
				if (sts.sweep_last) begin
					state_d = rac_pkg::ST_CHECK;
				end
			end
			rac_pkg::ST_CHECK: begin
				state_d = sts.base_lt2 ? rac_pkg::ST_ERR : rac_pkg::ST_DIV;
			end
			rac_pkg::ST_DIV: begin
				if (sts.div_last) begin
					state_d = rac_pkg::ST_NEXT;
				end
			end
			rac_pkg::ST_NEXT: begin
				if (sts.quot_zero || sts.count_full) begin
					state_d = rac_pkg::ST_RD;
				end else begin
					state_d = rac_pkg::ST_DIV;
				end
			end
			rac_pkg::ST_RD:    state_d = rac_pkg::ST_MAP;
			rac_pkg::ST_MAP:   state_d = rac_pkg::ST_EMIT;
			rac_pkg::ST_EMIT: begin
				state_d = sts.ptr_zero ? rac_pkg::ST_IDLE : rac_pkg::ST_RD;
			end
			rac_pkg::ST_EMPTY: state_d = rac_pkg::ST_IDLE;
			rac_pkg::ST_ERR:   state_d = rac_pkg::ST_IDLE;
			default:           state_d = rac_pkg::ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			rac_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			rac_pkg::ST_SWEEP: cmd.sweep = 1'b1;
			rac_pkg::ST_CHECK: cmd.div_start = !sts.base_lt2;
			rac_pkg::ST_DIV:   cmd.div_step = 1'b1;
			rac_pkg::ST_NEXT: begin
				if (sts.quot_zero || sts.count_full) begin
					cmd.out_init = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
				end
			end
			rac_pkg::ST_RD:  cmd.rd_digit = 1'b1;
			rac_pkg::ST_MAP: cmd.rd_map = 1'b1;
			rac_pkg::ST_EMIT: begin
				cmd.emit_digit = 1'b1;
				cmd.ptr_dec    = !sts.ptr_zero;
			end
			rac_pkg::ST_EMPTY: cmd.emit_empty = 1'b1;
			rac_pkg::ST_ERR:   cmd.emit_err = 1'b1;
			default: begin
				cmd  = '0;
				busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

### sv/rac_dp.sv
// Datapath of the radix converter: configuration, alphabet sweep, bit-serial
// divider, digit and symbol stores, result registers. Uses rac_pkg and rac_ram.
`timescale 1ns / 1ps
`default_nettype none

module rac_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [rac_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rac_pkg::MASK_W-1:0]          cfg_data,
	input  wire logic [rac_pkg::VALUE_BITS-1:0]      value,
	input  wire rac_pkg::cmd_t                       cmd,
	output rac_pkg::status_t                         sts,
	output logic                                     strobe,
	output logic      [rac_pkg::ASCII_W-1:0]         symbol,
	output logic      [rac_pkg::DV_W-1:0]            digit_value,
	output logic                                     last_digit,
	output logic                                     empty_result,
	output logic                                     base_error
);

	// Configuration
	logic [rac_pkg::SYM_COUNT_W-1:0] sym_count_q;
	logic [rac_pkg::MASK_W-1:0]      banned_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_count_q <= rac_pkg::SYM_COUNT_W'(36);
			banned_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rac_pkg::CFG_SYMBOL_COUNT: sym_count_q <= cfg_data[rac_pkg::SYM_COUNT_W-1:0];
				rac_pkg::CFG_BANNED_MASK:  banned_q    <= cfg_data;
				default:                   ;
			endcase
		end
	end

	logic [rac_pkg::SYM_COUNT_W-1:0] n_eff;
	assign n_eff = (sym_count_q > rac_pkg::SYM_COUNT_W'(rac_pkg::MAX_SYMBOLS))
		? rac_pkg::SYM_COUNT_W'(rac_pkg::MAX_SYMBOLS) : sym_count_q;

	// Alphabet sweep: count allowed symbols, record their positions
	logic [rac_pkg::SYM_IDX_W-1:0] sw_idx_q;
	logic [rac_pkg::BASE_W-1:0]    base_q;
	logic                          allowed;

	assign allowed = (rac_pkg::SYM_COUNT_W'(sw_idx_q) < n_eff) && !banned_q[sw_idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_idx_q <= '0;
			base_q   <= '0;
		end else if (cmd.load) begin
			sw_idx_q <= '0;
			base_q   <= '0;
		end else if (cmd.sweep) begin
			sw_idx_q <= sw_idx_q + 1'b1;
			if (allowed) begin
				base_q <= base_q + 1'b1;
			end
		end
	end

	// Bit-serial restoring divider: one quotient bit per cycle
	logic [rac_pkg::VALUE_BITS-1:0] val_q;
	logic [rac_pkg::BASE_W-1:0]     rem_q;
	logic [rac_pkg::BIT_CNT_W-1:0]  bit_q;
	logic [rac_pkg::BASE_W:0]       trial;
	logic [rac_pkg::BASE_W:0]       trial_sub;
	logic                           q_bit;
	logic [rac_pkg::BASE_W-1:0]     rem_next;
	logic [rac_pkg::CNT_W-1:0]      cnt_q;
	logic [rac_pkg::CNT_W-1:0]      ptr_q;

	assign trial     = {rem_q, val_q[rac_pkg::VALUE_BITS-1]};
	assign q_bit     = trial >= {1'b0, base_q};
	assign trial_sub = trial - {1'b0, base_q};
	assign rem_next  = q_bit ? trial_sub[rac_pkg::BASE_W-1:0] : trial[rac_pkg::BASE_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= value;
		end else if (cmd.div_step) begin
			val_q <= {val_q[rac_pkg::VALUE_BITS-2:0], q_bit};
		end
		if (cmd.div_start) begin
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
			cnt_q <= '0;
			ptr_q <= '0;
		end else begin
			if (cmd.div_start) begin
				bit_q <= '0;
			end else if (cmd.div_step) begin
				bit_q <= bit_q + 1'b1;
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.div_step && sts.div_last) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_init) begin
				ptr_q <= cnt_q - 1'b1;
			end else if (cmd.ptr_dec) begin
				ptr_q <= ptr_q - 1'b1;
			end
		end
	end

	// Stores
	logic [rac_pkg::DV_W-1:0]      digit_rdata;
	logic [rac_pkg::SYM_IDX_W-1:0] map_rdata;

	rac_ram #(
		.WIDTH(rac_pkg::DV_W),
		.DEPTH(rac_pkg::DIGIT_DEPTH)
	) u_digit_ram (
		.clk  (clk),
		.we   (cmd.div_step && sts.div_last),
		.waddr(cnt_q[rac_pkg::DIG_AW-1:0]),
		.wdata(rac_pkg::DV_W'(rem_next)),
		.re   (cmd.rd_digit),
		.raddr(ptr_q[rac_pkg::DIG_AW-1:0]),
		.rdata(digit_rdata)
	);

	rac_ram #(
		.WIDTH(rac_pkg::SYM_IDX_W),
		.DEPTH(rac_pkg::MAX_SYMBOLS)
	) u_map_ram (
		.clk  (clk),
		.we   (cmd.sweep && allowed),
		.waddr(base_q[rac_pkg::SYM_IDX_W-1:0]),
		.wdata(sw_idx_q),
		.re   (cmd.rd_map),
		.raddr(digit_rdata[rac_pkg::SYM_IDX_W-1:0]),
		.rdata(map_rdata)
	);

	// Status
	always_comb begin
		sts.in_zero    = value == '0;
		sts.sweep_last = sw_idx_q == rac_pkg::SYM_IDX_W'(rac_pkg::MAX_SYMBOLS - 1);
		sts.base_lt2   = base_q < rac_pkg::BASE_W'(2);
		sts.div_last   = bit_q == rac_pkg::BIT_CNT_W'(rac_pkg::VALUE_BITS - 1);
		sts.quot_zero  = val_q == '0;
		sts.count_full = cnt_q == rac_pkg::CNT_W'(rac_pkg::DIGIT_DEPTH);
		sts.ptr_zero   = ptr_q == '0;
	end

	// Result registers
	logic emit;
	assign emit = cmd.emit_digit || cmd.emit_empty || cmd.emit_err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			symbol       <= cmd.emit_digit ? rac_pkg::to_ascii(map_rdata) : '0;
			digit_value  <= cmd.emit_digit ? digit_rdata : '0;
			last_digit   <= !cmd.emit_digit || sts.ptr_zero;
			empty_result <= cmd.emit_empty;
			base_error   <= cmd.emit_err;
		end
	end

endmodule

`default_nettype wire

### sv/restricted_alphabet_radix_convert_top.sv
// Top level of the restricted-alphabet radix converter: ports, controller and datapath.
// Depends on rac_pkg, rac_ctrl, rac_dp and rac_ram.
`timescale 1ns / 1ps
`default_nettype none

// Writes a non-negative value in the base given by the allowed symbols of
// 0-9, A-Z (first symbol_count candidates, less those set in banned_mask).
// A value is taken when start is high while busy is low. Results come out
// most significant digit first, one beat per cycle of strobe, as the ASCII
// code plus the digit's value, with last_digit on the final beat. The
// receiver cannot stall: every beat is on the ports for exactly one cycle
// and must be taken then. A zero value yields one beat flagged empty_result;
// fewer than two allowed symbols yields one beat flagged base_error.
// Steps: a zero value goes straight to its empty beat. Otherwise a sweep
// over the alphabet works out the base, then a check either emits the base
// error beat or starts the bit-serial divider, one quotient bit a cycle over
// 63 bits, plus a decision state per digit. Once every digit is divided out,
// each is read back and translated, most significant first; a value has at
// most 63 digits (in base 2). The strobe of each beat is registered, in the
// cycle after the one that issues it. Configuration writes are taken whenever
// busy is low.
module restricted_alphabet_radix_convert_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [rac_pkg::VALUE_BITS-1:0] value,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rac_pkg::MASK_W-1:0]     cfg_data,
	output logic                                strobe,
	output logic      [rac_pkg::ASCII_W-1:0]    symbol,
	output logic      [rac_pkg::DV_W-1:0]       digit_value,
	output logic                                last_digit,
	output logic                                empty_result,
	output logic                                base_error
);

	rac_pkg::cmd_t    cmd;
	rac_pkg::status_t sts;

	// Hold configuration writes off while a value is in flight
	assign cfg_ready = !busy;

	rac_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.busy  (busy),
		.cmd   (cmd)
	);

	rac_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.value       (value),
		.cmd         (cmd),
		.sts         (sts),
		.strobe      (strobe),
		.symbol      (symbol),
		.digit_value (digit_value),
		.last_digit  (last_digit),
		.empty_result(empty_result),
		.base_error  (base_error)
	);

endmodule

`default_nettype wire

### sim/rac_digit_checker.sv
// Scoreboard for the restricted-alphabet radix converter: watches the value, configuration
// and digit channels, predicts every digit beat and compares. Depends on rac_pkg.
`timescale 1ns / 1ps

module rac_digit_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [rac_pkg::VALUE_BITS-1:0] value,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [rac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rac_pkg::MASK_W-1:0]     cfg_data,
	input  logic                           strobe,
	input  logic [rac_pkg::ASCII_W-1:0]    symbol,
	input  logic [rac_pkg::DV_W-1:0]       digit_value,
	input  logic                           last_digit,
	input  logic                           empty_result,
	input  logic                           base_error,
	output int                             failures,
	output int                             pending,
	output int                             values_taken,
	output int                             beats_seen,
	output int                             empty_seen,
	output int                             error_seen
);
	import rac_pkg::*;

	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [ASCII_W-1:0] symbol;
		logic [DV_W-1:0]    digit_value;
		logic               last_digit;
		logic               empty_result;
		logic               base_error;
	} digit_beat_t;

	digit_beat_t            expected_beats[$];
	logic [SYM_COUNT_W-1:0] alphabet_size;
	logic [MASK_W-1:0]      banned;

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		failures++;
		if (failures <= PRINT_CAP) begin
			$display("[%0t] beat %0d: %s is %0d, want %0d", $time, beats_seen, what, got, want);
		end
	endtask

	// Write v in the base of the current alphabet and queue its beats, most
	// significant digit first.
	function automatic void predict_digits(input logic [VALUE_BITS-1:0] v);
		int unsigned           n;
		int unsigned           radix;
		int unsigned           ndig;
		int unsigned           pos;
		int unsigned           rank;
		logic                  hit;
		logic [VALUE_BITS-1:0] rest;
		logic [VALUE_BITS-1:0] radix_w;
		logic [DV_W-1:0]       remainders [DIGIT_DEPTH];
		digit_beat_t           beat;

		// counts above the alphabet size saturate
		n = (alphabet_size > MAX_SYMBOLS) ? MAX_SYMBOLS : alphabet_size;
		radix = 0;
		for (int i = 0; i < n; i++) begin
			if (!banned[i]) radix++;
		end

		beat = '0;
		beat.last_digit = 1'b1;
		// a zero value is flagged empty whatever the base
		if (v == '0) begin
			beat.empty_result = 1'b1;
			expected_beats.push_back(beat);
			return;
		end
		if (radix < 2) begin
			beat.base_error = 1'b1;
			expected_beats.push_back(beat);
			return;
		end

		rest = v;
		radix_w = VALUE_BITS'(radix);
		ndig = 0;
		while (rest != '0 && ndig < DIGIT_DEPTH) begin
			remainders[ndig] = DV_W'(rest % radix_w);
			rest = rest / radix_w;
			ndig++;
		end

		for (int k = ndig - 1; k >= 0; k--) begin
			// the digit selects the rank-th allowed symbol in alphabet order
			rank = 32'(remainders[k]);
			pos = 0;
			hit = 1'b0;
			for (int i = 0; i < n; i++) begin
				if (!banned[i] && !hit) begin
					if (rank == 0) begin
						pos = i;
						hit = 1'b1;
					end else begin
						rank--;
					end
				end
			end
			beat = '0;
			beat.digit_value = remainders[k];
			beat.symbol = (pos < DECIMAL_DIGITS) ? CHAR_ZERO + ASCII_W'(pos)
				: CHAR_A + (ASCII_W'(pos) - DECIMAL_DIGITS);
			beat.last_digit = (k == 0);
			expected_beats.push_back(beat);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		digit_beat_t want;
		if (!arst_n) begin
			alphabet_size = SYM_COUNT_W'(MAX_SYMBOLS);
			banned = '0;
			expected_beats.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SYMBOL_COUNT) begin
					alphabet_size = cfg_data[SYM_COUNT_W-1:0];
				end else if (cfg_index == CFG_BANNED_MASK) begin
					banned = cfg_data;
				end
			end
			// take result beats before new values so a stray beat is never matched
			// against a value accepted on the same edge
			if (strobe) begin
				beats_seen++;
				if (empty_result) empty_seen++;
				if (base_error) error_seen++;
				if (expected_beats.size() == 0) begin
					flag_mismatch("unexpected beat, symbol", symbol, 0);
				end else begin
					want = expected_beats.pop_front();
					if (symbol !== want.symbol) begin
						flag_mismatch("symbol", symbol, want.symbol);
					end
					if (digit_value !== want.digit_value) begin
						flag_mismatch("digit_value", digit_value, want.digit_value);
					end
					if (last_digit !== want.last_digit) begin
						flag_mismatch("last_digit", last_digit, want.last_digit);
					end
					if (empty_result !== want.empty_result) begin
						flag_mismatch("empty_result", empty_result, want.empty_result);
					end
					if (base_error !== want.base_error) begin
						flag_mismatch("base_error", base_error, want.base_error);
					end
				end
			end
			if (start && !busy) begin
				values_taken++;
				predict_digits(value);
			end
			pending <= expected_beats.size();
		end
	end

endmodule

### sim/restricted_alphabet_radix_convert_top_test.sv
// Testbench top for the restricted-alphabet radix converter: clock, reset, value and
// configuration stimulus and the verdict. Depends on rac_pkg, the block and rac_digit_checker.
`timescale 1ns / 1ps

module restricted_alphabet_radix_convert_top_test;
	import rac_pkg::*;

	localparam int     HALF_PERIOD      = 5;
	localparam int     RESET_CYCLES     = 9;
	// wait a little longer than one digit takes, to catch stray beats
	localparam int     SETTLE_CYCLES    = 80;
	localparam int     RANDOM_PHASES    = 8;
	localparam int     VALUES_PER_PHASE = 15;
	// about 150 values at the worst-case busy time each, taken several times over
	localparam longint WATCHDOG_NS      = 40_000_000;

	// indexes that map to no register: writes there must change nothing
	localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_3 = 2'd3;
	localparam logic [VALUE_BITS-1:0] VALUE_MAX   = '1;
	localparam logic [MASK_W-1:0]     BAN_ALL     = '1;
	localparam logic [MASK_W-1:0]     BAN_DECIMAL = 36'h3FF;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [VALUE_BITS-1:0]  value;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [MASK_W-1:0]      cfg_data;
	logic                   strobe;
	logic [ASCII_W-1:0]     symbol;
	logic [DV_W-1:0]        digit_value;
	logic                   last_digit;
	logic                   empty_result;
	logic                   base_error;

	int failures;
	int pending;
	int values_taken;
	int beats_seen;
	int empty_seen;
	int error_seen;
	int settings;

	restricted_alphabet_radix_convert_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.strobe(strobe),
		.symbol(symbol),
		.digit_value(digit_value),
		.last_digit(last_digit),
		.empty_result(empty_result),
		.base_error(base_error)
	);

	rac_digit_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.strobe(strobe),
		.symbol(symbol),
		.digit_value(digit_value),
		.last_digit(last_digit),
		.empty_result(empty_result),
		.base_error(base_error),
		.failures(failures),
		.pending(pending),
		.values_taken(values_taken),
		.beats_seen(beats_seen),
		.empty_seen(empty_seen),
		.error_seen(error_seen)
	);

	always #HALF_PERIOD clk = ~clk;

	// Watchdog: a hung handshake ends the run here.
	initial begin
		#(WATCHDOG_NS);
		$display("Watchdog expired with %0d beats still expected", pending);
		$display("Verification failed");
		$finish;
	end

	// Present one value and hold it until the block takes it. Start is left high
	// so that a value following straight on keeps the request asserted.
	task automatic send_value(input logic [VALUE_BITS-1:0] v);
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Drop start for a random stretch; pct is the chance, in a hundred, of each
	// further idle cycle. Scramble the value bus while nothing is offered.
	task automatic sender_gap(input int pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			do begin
				value <= VALUE_BITS'({$urandom, $urandom});
				@(posedge clk);
			end while ($urandom_range(99) < pct);
		end
	endtask

	// Hold off until every predicted beat has arrived. The first edge lets the
	// checker's count catch up with a value taken on the current edge.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// One configuration beat; valid is left high for a following write.
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Drain the block, then load a new alphabet in random register order and
	// poke one unmapped index with noise.
	task automatic program_alphabet(input logic [SYM_COUNT_W-1:0] count,
			input logic [MASK_W-1:0] mask);
		logic [63:0] noise;
		logic [MASK_W-1:0] count_word;
		noise = {$urandom, $urandom};
		// upper bits of a count write carry noise; only the low six matter
		count_word = {noise[MASK_W-1:SYM_COUNT_W], count};
		wait_drained();
		if ($urandom_range(1) == 0) begin
			put_reg(CFG_SYMBOL_COUNT, count_word);
			put_reg(CFG_BANNED_MASK, mask);
		end else begin
			put_reg(CFG_BANNED_MASK, mask);
			put_reg(CFG_SYMBOL_COUNT, count_word);
		end
		put_reg(($urandom_range(1) == 0) ? CFG_SPARE_2 : CFG_SPARE_3, ~noise[MASK_W-1:0]);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Mostly short values to keep base-2 runs cheap, with some zeros, some full
	// width and some just around the base.
	function automatic logic [VALUE_BITS-1:0] random_value();
		logic [63:0]           raw;
		logic [VALUE_BITS-1:0] pick;
		raw = {$urandom, $urandom};
		pick = raw[VALUE_BITS-1:0];
		case ($urandom_range(15))
			0: pick = '0;
			1, 2: pick = raw[VALUE_BITS-1:0];
			3: pick = VALUE_BITS'($urandom_range(40));
			default: pick = raw[VALUE_BITS-1:0] >> $urandom_range(62, 24);
		endcase
		return pick;
	endfunction

	initial begin
		logic [63:0]            noise;
		logic [SYM_COUNT_W-1:0] count;
		logic [MASK_W-1:0]      mask;
		int                     idle_pct;

		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SYMBOL_COUNT;
		cfg_data = '0;
		settings = 1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling. Reset alphabet first: all of 0-9, A-Z, base 36.
		send_value('0);
		send_value(63'd1);
		send_value(63'd35);
		send_value(63'd36);
		send_value(63'd1295);
		send_value(VALUE_MAX);
		send_value(VALUE_MAX / 3);
		send_value(VALUE_MAX ^ (VALUE_MAX / 3));

		// Smallest working base: the longest digit strings.
		program_alphabet(6'd2, '0);
		send_value(VALUE_MAX);
		send_value(VALUE_MAX ^ (VALUE_MAX >> 1));
		send_value(63'd1);
		send_value('0);

		// One symbol: base error, though a zero value still reads as empty.
		program_alphabet(6'd1, '0);
		send_value(63'd5);
		send_value('0);

		// No symbol at all.
		program_alphabet(6'd0, BAN_ALL);
		send_value(63'd7);

		// Count above the alphabet saturates; everything banned leaves base zero.
		program_alphabet(6'd63, BAN_ALL);
		send_value(63'd1);

		// Only H and Z left: base 2 drawn from the far end of the alphabet.
		program_alphabet(6'd63, BAN_ALL ^ (36'd1 << 35) ^ (36'd1 << 17));
		send_value(63'd6);

		// Ban bits beyond the count must be ignored: plain decimal.
		program_alphabet(6'd10, BAN_ALL << 10);
		send_value(63'd9876543210);

		// Letters only, base 26.
		program_alphabet(6'd36, BAN_DECIMAL);
		send_value(VALUE_MAX);

		// Saturated count with the zero symbol banned: base 35.
		program_alphabet(6'd40, 36'd1);
		send_value(63'd12345);

		// Random part: a fresh alphabet per phase, idling rotating between none,
		// heavy and light.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			noise = {$urandom, $urandom};
			if ($urandom_range(4) == 0) begin
				case ($urandom_range(4))
					0: count = 6'd0;
					1: count = 6'd1;
					2: count = 6'd2;
					3: count = 6'd36;
					default: count = 6'd63;
				endcase
			end else begin
				count = SYM_COUNT_W'($urandom_range(2, 63));
			end
			// sparse bans keep most bases usable
			mask = noise[MASK_W-1:0] & MASK_W'({$urandom, $urandom});
			if ($urandom_range(3) == 0) mask = '0;
			case (phase % 3)
				0: idle_pct = 0;
				1: idle_pct = 72;
				default: idle_pct = 29;
			endcase
			program_alphabet(count, mask);
			for (int k = 0; k < VALUES_PER_PHASE; k++) begin
				sender_gap(idle_pct);
				// hold off mid-phase until the block has emptied
				if ((phase == 1 && k == 7) || $urandom_range(11) == 0) wait_drained();
				send_value(random_value());
			end
		end

		// Wait for the last digits, then a little longer to catch stray beats.
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Converted %0d values into %0d digit beats (%0d empty, %0d base errors)",
			values_taken, beats_seen, empty_seen, error_seen);
		$display("across %0d alphabet settings; %0d mismatches, %0d beats missing",
			settings, failures, pending);
		if (failures == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### files.f
sv/rac_pkg.sv
sv/rac_ram.sv
sv/rac_ctrl.sv
sv/rac_dp.sv
sv/restricted_alphabet_radix_convert_top.sv
sim/rac_digit_checker.sv
sim/restricted_alphabet_radix_convert_top_test.sv
